// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. The clock is clock and the reset is reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrs_pkg
// Codes, reset values and types of the timed servo route sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsrs_pkg;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TAKE  = 2'd2;
   localparam logic [1:0] KIND_HOME  = 2'd3;

   // material classes
   localparam logic [1:0] MAT_PLASTIC = 2'd0;
   localparam logic [1:0] MAT_GLASS   = 2'd1;

   // phase codes
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_ROTATING  = 3'd1;
   localparam logic [2:0] PH_OPENING   = 3'd2;
   localparam logic [2:0] PH_CLOSING   = 3'd3;
   localparam logic [2:0] PH_RETURNING = 3'd4;

   // register indexes
   localparam logic [2:0] REG_ANGLE_PLASTIC = 3'd0;
   localparam logic [2:0] REG_ANGLE_GLASS   = 3'd1;
   localparam logic [2:0] REG_ANGLE_REJECT  = 3'd2;
   localparam logic [2:0] REG_ANGLE_HOME    = 3'd3;
   localparam logic [2:0] REG_GATE_OPEN     = 3'd4;
   localparam logic [2:0] REG_SETTLE_TICKS  = 3'd5;
   localparam logic [2:0] REG_OPEN_TICKS    = 3'd6;
   localparam logic [2:0] REG_CLOSE_TICKS   = 3'd7;

   // register reset values
   localparam logic [7:0]  RST_ANGLE_PLASTIC = 8'd45;
   localparam logic [7:0]  RST_ANGLE_GLASS   = 8'd135;
   localparam logic [7:0]  RST_ANGLE_REJECT  = 8'd0;
   localparam logic [7:0]  RST_ANGLE_HOME    = 8'd90;
   localparam logic [7:0]  RST_GATE_OPEN     = 8'd90;
   localparam logic [15:0] RST_SETTLE_TICKS  = 16'd400;
   localparam logic [15:0] RST_OPEN_TICKS    = 16'd500;
   localparam logic [15:0] RST_CLOSE_TICKS   = 16'd300;

   localparam logic [7:0] GATE_CLOSED_ANGLE = 8'd0;

   // one result transfer
   typedef struct packed {
      logic       accepted;
      logic [7:0] rotation_angle;
      logic [7:0] gate_angle;
      logic       busy_res;
      logic       completed;
      logic [2:0] phase_now;
   } rsp_type;

endpackage

// ===== rtl/core/timed_servo_route_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// timed_servo_route_sequencer_top
// Chute rotation and gate sequencer driven by tick, start, take and home
// requests, with one result per request.
// ----------------------------------------------------------------------------
// Every request yields one result, held in the result register or, while that
// register is stalled, in the skid entry; a request can be taken every cycle
// while req_stall is low. The state update is a single combinational pass
// from the request port into the result register. A one-entry skid stage sits
// behind the result register, so req_stall is high exactly when the skid entry
// is full; the request rate is then set by how fast the result side drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timed_servo_route_sequencer_top
   import tsrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_material,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_rotation_angle,
   output logic [7:0]  rsp_gate_angle,
   output logic        rsp_busy_res,
   output logic        rsp_completed,
   output logic [2:0]  rsp_phase_now,
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [7:0]  angle_plastic_ff, angle_glass_ff, angle_reject_ff, angle_home_ff;
   logic [7:0]  gate_open_ff;
   logic [15:0] settle_ticks_ff, open_ticks_ff, close_ticks_ff;

   // sequencer state
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] remain_ff, remain_in;
   logic        done_ff, done_in;
   logic [7:0]  rot_ff, rot_in;
   logic [7:0]  gate_ff, gate_in;

   // result register and skid entry
   logic        rsp_valid_ff, skid_valid_ff;
   rsp_type     rsp_ff, skid_ff;
   rsp_type     result;

   logic        req_xfer;
   logic        rsp_xfer;
   logic        started;
   logic        comp;
   logic [15:0] remain_dec;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // register write port
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_plastic_ff <= RST_ANGLE_PLASTIC;
         angle_glass_ff   <= RST_ANGLE_GLASS;
         angle_reject_ff  <= RST_ANGLE_REJECT;
         angle_home_ff    <= RST_ANGLE_HOME;
         gate_open_ff     <= RST_GATE_OPEN;
         settle_ticks_ff  <= RST_SETTLE_TICKS;
         open_ticks_ff    <= RST_OPEN_TICKS;
         close_ticks_ff   <= RST_CLOSE_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            REG_ANGLE_PLASTIC: angle_plastic_ff <= csr_wdata[7:0];
            REG_ANGLE_GLASS:   angle_glass_ff   <= csr_wdata[7:0];
            REG_ANGLE_REJECT:  angle_reject_ff  <= csr_wdata[7:0];
            REG_ANGLE_HOME:    angle_home_ff    <= csr_wdata[7:0];
            REG_GATE_OPEN:     gate_open_ff     <= csr_wdata[7:0];
            REG_SETTLE_TICKS:  settle_ticks_ff  <= csr_wdata;
            REG_OPEN_TICKS:    open_ticks_ff    <= csr_wdata;
            REG_CLOSE_TICKS:   close_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state for one request
   assign remain_dec = (remain_ff != 16'd0) ? remain_ff - 16'd1 : 16'd0;

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      done_in   = done_ff;
      rot_in    = rot_ff;
      gate_in   = gate_ff;
      started   = 1'b0;
      comp      = 1'b0;
      case (req_kind)
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               remain_in = remain_dec;
               if (remain_dec == 16'd0) begin
                  case (phase_ff)
                     PH_ROTATING: begin
                        gate_in   = gate_open_ff;
                        phase_in  = PH_OPENING;
                        remain_in = open_ticks_ff;
                     end
                     PH_OPENING: begin
                        gate_in   = GATE_CLOSED_ANGLE;
                        phase_in  = PH_CLOSING;
                        remain_in = close_ticks_ff;
                     end
                     PH_CLOSING: begin
                        rot_in    = angle_home_ff;
                        phase_in  = PH_RETURNING;
                        remain_in = settle_ticks_ff;
                     end
                     default: begin
                        phase_in  = PH_IDLE;
                        remain_in = 16'd0;
                        done_in   = 1'b1;
                     end
                  endcase
               end
            end
         end
         KIND_START: begin
            if (phase_ff == PH_IDLE) begin
               case (req_material)
                  MAT_PLASTIC: rot_in = angle_plastic_ff;
                  MAT_GLASS:   rot_in = angle_glass_ff;
                  default:     rot_in = angle_reject_ff;
               endcase
               phase_in  = PH_ROTATING;
               remain_in = settle_ticks_ff;
               started   = 1'b1;
            end
         end
         KIND_TAKE: begin
            comp    = done_ff;
            done_in = 1'b0;
         end
         default: begin
            rot_in    = angle_home_ff;
            gate_in   = GATE_CLOSED_ANGLE;
            phase_in  = PH_IDLE;
            remain_in = 16'd0;
         end
      endcase
   end

   // result from the updated state
   always_comb begin
      result.accepted       = started;
      result.rotation_angle = rot_in;
      result.gate_angle     = gate_in;
      result.busy_res       = (phase_in != PH_IDLE);
      result.completed      = comp;
      result.phase_now      = phase_in;
   end

   // state update on request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         remain_ff <= 16'd0;
         done_ff   <= 1'b0;
         rot_ff    <= RST_ANGLE_HOME;
         gate_ff   <= GATE_CLOSED_ANGLE;
      end else if (req_xfer) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         done_ff   <= done_in;
         rot_ff    <= rot_in;
         gate_ff   <= gate_in;
      end
   end

   // result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_xfer) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= req_xfer;
         end
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_xfer) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (req_xfer) begin
            rsp_ff <= result;
         end
      end else if (req_xfer) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_ff.accepted;
   assign rsp_rotation_angle = rsp_ff.rotation_angle;
   assign rsp_gate_angle     = rsp_ff.gate_angle;
   assign rsp_busy_res       = rsp_ff.busy_res;
   assign rsp_completed      = rsp_ff.completed;
   assign rsp_phase_now      = rsp_ff.phase_now;

   // checks
   `ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, rsp_valid_ff)
   `ASSERT_IMPL(a_idle_no_timer, phase_ff == PH_IDLE, remain_ff == 16'd0)
   `ASSERT_NEXT(a_start_enters_rotating, req_xfer && req_kind == KIND_START && phase_ff == PH_IDLE, phase_ff == PH_ROTATING)
   `ASSERT_NEXT(a_home_forces_idle, req_xfer && req_kind == KIND_HOME, phase_ff == PH_IDLE && gate_ff == GATE_CLOSED_ANGLE)

endmodule
